### src/afol_pkg.sv
// ----------------------------------------------------------------------------
// afol_pkg
// Shared types and constants of the adaptive first-order low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package afol_pkg;

   localparam int TABLE_ENTRIES = 4;
   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 17;
   localparam int GAIN_SHIFT    = 16;
   localparam int LEN_W         = 3;
   localparam int ENTRY_W       = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_RELOAD      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_LIMIT       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TABLE_LEN        = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLDS       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INCREMENTS       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INCREMENT_BEYOND = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_LIMIT_RESET = 17'd65536;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef struct packed {
      logic [GAIN_W-1:0]               gain_reload;
      logic [GAIN_W-1:0]               gain_limit;
      logic [LEN_W-1:0]                table_len;
      logic [3:0][ENTRY_W-1:0]         thresholds;
      logic [3:0][ENTRY_W-1:0]         increments;
      logic [ENTRY_W-1:0]              increment_beyond;
   } cfg_type;

endpackage

`default_nettype wire

### src/afol_csr.sv
// ----------------------------------------------------------------------------
// afol_csr
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
`default_nettype none

module afol_csr
   import afol_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_GAIN_RELOAD:      cfg_in.gain_reload      = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_LIMIT:       cfg_in.gain_limit       = csr_wdata[GAIN_W-1:0];
            CSR_TABLE_LEN:        cfg_in.table_len        = csr_wdata[LEN_W-1:0];
            CSR_THRESHOLDS:       cfg_in.thresholds       = csr_wdata;
            CSR_INCREMENTS:       cfg_in.increments       = csr_wdata;
            CSR_INCREMENT_BEYOND: cfg_in.increment_beyond = csr_wdata[ENTRY_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_reload      <= '0;
         cfg_ff.gain_limit       <= GAIN_LIMIT_RESET;
         cfg_ff.table_len        <= '0;
         cfg_ff.thresholds       <= '0;
         cfg_ff.increments       <= '0;
         cfg_ff.increment_beyond <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/afol_gain.sv
// ----------------------------------------------------------------------------
// afol_gain
// Error sign tracking and adaptive gain update: reload on a sign change,
// otherwise grow by the table increment and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module afol_gain
   import afol_pkg::*;
(
   input  wire cfg_type                 cfg,
   input  wire logic signed [SAMPLE_W:0] err,
   input  wire sign_type                sign_prev,
   input  wire logic [GAIN_W-1:0]       gain_prev,
   output sign_type                     sign_next,
   output logic                         flip,
   output logic [GAIN_W-1:0]            gain_next
);

   logic [SAMPLE_W-1:0] mag;
   logic [LEN_W-1:0]    len_eff;
   logic [ENTRY_W-1:0]  inc;
   logic [GAIN_W:0]     sum;

   always_comb begin
      if (err > 0) begin
         sign_next = SIGN_POS;
      end else if (err < 0) begin
         sign_next = SIGN_NEG;
      end else begin
         sign_next = SIGN_NONE;
      end
   end

   always_comb begin
      unique case (sign_next)
         SIGN_POS: flip = (sign_prev == SIGN_NEG);
         SIGN_NEG: flip = (sign_prev == SIGN_POS);
         default:  flip = 1'b0;
      endcase
   end

   // |err| never exceeds 65535
   assign mag = err[SAMPLE_W] ? SAMPLE_W'(-err) : err[SAMPLE_W-1:0];

   assign len_eff = (cfg.table_len > LEN_W'(TABLE_ENTRIES)) ? LEN_W'(TABLE_ENTRIES)
                                                            : cfg.table_len;

   // first matching entry wins
   always_comb begin
      inc = cfg.increment_beyond;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if ((LEN_W'(i) < len_eff) && (cfg.thresholds[i] > mag)) begin
            inc = cfg.increments[i];
         end
      end
   end

   assign sum = {1'b0, gain_prev} + {2'b00, inc};

   always_comb begin
      if (flip) begin
         gain_next = cfg.gain_reload;
      end else if (sum > {1'b0, cfg.gain_limit}) begin
         gain_next = cfg.gain_limit;
      end else begin
         gain_next = sum[GAIN_W-1:0];
      end
   end

endmodule

`default_nettype wire

### src/adaptive_first_order_lowpass.sv
// ----------------------------------------------------------------------------
// adaptive_first_order_lowpass
// Adaptive exponential moving average of a signed 16-bit sample stream.
// ----------------------------------------------------------------------------
//  channel  ports            dir  payload
//  req      req_t*           in   tdata[15:0] raw_sample
//  rsp      rsp_t*           out  tdata[15:0] filtered_sample
//  csr      csr_wen/addr/..  in   register index, 64-bit write data
//
//  One sample per cycle sustained while rsp is not stalled; a sample sits in the
//  input register, the gain update, one 18x17 multiply and the add are
//  combinational, and the filter state and the result register load together.
//  From a req transfer a sample passes the input register, then the result register.
//  A stalled rsp side holds the result; one more sample waits in the input
//  register. Synchronous reset clears the state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_first_order_lowpass
   import afol_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [15:0] raw_sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] filtered_sample
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] raw_ff;
   logic                       out_valid_ff;
   logic        [SAMPLE_W-1:0] out_data_ff;

   logic signed [SAMPLE_W-1:0] fv_ff;
   logic signed [SAMPLE_W-1:0] fv_in;
   sign_type                   sign_ff;
   sign_type                   sign_in;
   logic        [GAIN_W-1:0]   gain_ff;
   logic        [GAIN_W-1:0]   gain_in;

   logic                       advance;
   logic                       flip;
   logic signed [SAMPLE_W:0]   err;
   logic signed [GAIN_W+SAMPLE_W+1:0] prod;

   afol_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign err = {raw_ff[SAMPLE_W-1], raw_ff} - {fv_ff[SAMPLE_W-1], fv_ff};

   afol_gain u_gain (
      .cfg       (cfg),
      .err       (err),
      .sign_prev (sign_ff),
      .gain_prev (gain_ff),
      .sign_next (sign_in),
      .flip      (flip),
      .gain_next (gain_in)
   );

   // floor(gain * err / 2^16), only the low 16 bits survive the wrap
   assign prod  = $signed({1'b0, gain_in}) * err;
   assign fv_in = fv_ff + prod[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fv_ff        <= '0;
         sign_ff      <= SIGN_NONE;
         gain_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            fv_ff        <= fv_in;
            sign_ff      <= sign_in;
            gain_ff      <= gain_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         raw_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= fv_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // the result on offer is always the current filter state
   a_result_is_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff == fv_ff))
      else $error("result register differs from filter state");

   // growth path never leaves the gain above the clamp in force
   a_gain_clamped: assert property (@(posedge clock) disable iff (reset)
      (advance && !flip) |=> (gain_ff <= $past(cfg.gain_limit)))
      else $error("adaptive gain above its limit after growth");

   // a sign change reloads the gain
   a_flip_reload: assert property (@(posedge clock) disable iff (reset)
      (advance && flip) |=> (gain_ff == $past(cfg.gain_reload)))
      else $error("gain not reloaded on error sign change");

   // a waiting sample is neither lost nor overwritten
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(raw_ff)))
      else $error("pending sample dropped");
`endif

endmodule

`default_nettype wire

### sim/tb_adaptive_first_order_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_first_order_lowpass
// Self-checking bench for the adaptive low-pass filter. Samples are streamed
// in under random back-pressure on both sides. Every accepted sample updates
// a local model of the filter state, gain and settings, which queues the
// expected filtered value. Each result transfer is checked in order against
// that queue. The settings are reprogrammed between bursts, each time once
// the filter has drained: reset values, hand-picked corner settings, all-ones
// and all-zeros settings, and random ones.
// ----------------------------------------------------------------------------

module tb_adaptive_first_order_lowpass;
   import afol_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;

   class lowpass_scoreboard;
      cfg_type            cfg;
      logic signed [15:0] filt;
      sign_type           last_sign;
      logic [GAIN_W-1:0]  gain;
      logic [15:0]        expected_filtered[$];
      int                 mismatches;

      function new();
         cfg            = '0;
         cfg.gain_limit = GAIN_LIMIT_RESET;
         filt           = '0;
         last_sign      = SIGN_NONE;
         gain           = '0;
         mismatches     = 0;
      endfunction

      function void apply_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_GAIN_RELOAD:      cfg.gain_reload      = data[GAIN_W-1:0];
            CSR_GAIN_LIMIT:       cfg.gain_limit       = data[GAIN_W-1:0];
            CSR_TABLE_LEN:        cfg.table_len        = data[LEN_W-1:0];
            CSR_THRESHOLDS:       cfg.thresholds       = data;
            CSR_INCREMENTS:       cfg.increments       = data;
            CSR_INCREMENT_BEYOND: cfg.increment_beyond = data[ENTRY_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [15:0] raw);
         int            err;
         int            mag;
         int            eff_len;
         sign_type      dir;
         logic [15:0]   step_inc;
         longint        grown;
         longint        delta;
         err = int'(raw) - int'(filt);
         dir = (err > 0) ? SIGN_POS : ((err < 0) ? SIGN_NEG : SIGN_NONE);
         if ((dir == SIGN_POS && last_sign == SIGN_NEG) ||
             (dir == SIGN_NEG && last_sign == SIGN_POS)) begin
            gain = cfg.gain_reload;
         end else begin
            eff_len  = (cfg.table_len > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg.table_len);
            mag      = (err < 0) ? -err : err;
            step_inc = cfg.increment_beyond;
            // walk down so the lowest matching entry wins
            for (int i = eff_len - 1; i >= 0; i--) begin
               if (int'(cfg.thresholds[i]) > mag) step_inc = cfg.increments[i];
            end
            grown = longint'(gain) + longint'(step_inc);
            if (grown > longint'(cfg.gain_limit)) grown = longint'(cfg.gain_limit);
            gain = grown[GAIN_W-1:0];
         end
         last_sign = dir;
         delta = (longint'(gain) * longint'(err)) >>> GAIN_SHIFT;
         filt  = filt + delta[15:0];
         expected_filtered.push_back(filt);
      endfunction

      function void check_filtered(logic [15:0] actual);
         logic [15:0] want;
         if (expected_filtered.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected filtered_sample %0d, nothing outstanding", $signed(actual));
            return;
         end
         want = expected_filtered.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("filtered_sample mismatch: expected %0d, got %0d",
                        $signed(want), $signed(actual));
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // [15:0] raw_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;         // [15:0] filtered_sample
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   bit                    stall_enable = 1'b1;
   lowpass_scoreboard     tracker;

   adaptive_first_order_lowpass u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) tracker.check_filtered(rsp_tdata);
      rsp_tready <= stall_enable ? ($urandom_range(99) >= 20) : 1'b1;
   end

   task automatic send_sample(input logic [15:0] raw);
      if (stall_enable && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample($signed(raw));
   endtask

   task automatic await_filter_idle();
      req_tvalid <= 1'b0;
      while (tracker.expected_filtered.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      tracker.apply_reg(addr, data);
   endtask

   task automatic program_filter(input logic [GAIN_W-1:0]  amin,
                                 input logic [GAIN_W-1:0]  amax,
                                 input logic [LEN_W-1:0]   len,
                                 input logic [63:0]        thr,
                                 input logic [63:0]        inc,
                                 input logic [ENTRY_W-1:0] beyond);
      write_reg(CSR_GAIN_RELOAD, 64'(amin));
      write_reg(CSR_GAIN_LIMIT, 64'(amax));
      write_reg(CSR_TABLE_LEN, 64'(len));
      write_reg(CSR_THRESHOLDS, thr);
      write_reg(CSR_INCREMENTS, inc);
      write_reg(CSR_INCREMENT_BEYOND, 64'(beyond));
      // unmapped index, must leave every setting alone
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      csr_wen <= 1'b0;
   endtask

   function automatic logic [GAIN_W-1:0] gain_pick();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 17'd65536;
         2:       return 17'h1FFFF;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic run_random_burst(input int count);
      logic [15:0] s;
      logic [15:0] level;
      logic [15:0] previous;
      logic [15:0] hi;
      logic [15:0] lo;
      bit          toggle;
      level    = 16'($urandom);
      previous = level;
      hi       = 16'($urandom);
      lo       = 16'($urandom);
      toggle   = 1'b0;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: s = 16'($urandom);
            3, 4, 5: begin
               level = level + 16'($urandom_range(0, 128)) - 16'd64;
               s     = level;
            end
            6, 7: begin
               s      = toggle ? hi : lo;
               toggle = !toggle;
            end
            8: begin
               case ($urandom_range(0, 2))
                  0:       s = 16'h7FFF;
                  1:       s = 16'h8000;
                  default: s = 16'h0000;
               endcase
            end
            default: s = previous;
         endcase
         send_sample(s);
         previous = s;
      end
   endtask

   logic [15:0] reset_run [3]  = '{16'h1234, 16'h8000, 16'h7FFF};
   logic [15:0] corner_run [14] = '{16'h0000, 16'h0005, 16'h0032, -16'sd50, -16'sd50,
                                    16'd500, 16'd5000, 16'h7FFF, 16'h8000, 16'h8000,
                                    16'h7FFF, 16'h0001, 16'hFFFF, 16'h5555};
   logic [15:0] over_run [5]   = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000};
   logic [15:0] wrap_run [3]   = '{16'h7FFF, 16'h7FFF, 16'h7FFF};

   initial begin
      logic [63:0] thr;
      logic [63:0] inc;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: gain never grows
      foreach (reset_run[i]) send_sample(reset_run[i]);
      await_filter_idle();

      // oversized table length, every table entry reachable
      program_filter(17'd8192, GAIN_LIMIT_RESET, 3'd7,
                     {16'd30000, 16'd1000, 16'd100, 16'd10},
                     {16'h8000, 16'h2000, 16'h0800, 16'h0100}, 16'hFFFF);
      foreach (corner_run[i]) send_sample(corner_run[i]);
      await_filter_idle();

      // sign change loads a gain above the clamp
      program_filter(17'h1FFFF, 17'd40000, 3'd0, '0, '0, 16'hFFFF);
      foreach (over_run[i]) send_sample(over_run[i]);
      await_filter_idle();

      // gain beyond unity, filtered value wraps
      program_filter('0, 17'h1FFFF, 3'd0, '0, '0, 16'hFFFF);
      foreach (wrap_run[i]) send_sample(wrap_run[i]);
      await_filter_idle();

      for (int p = 0; p < 8; p++) begin
         stall_enable = (p != 3);
         if (p == 0) begin
            program_filter(17'h1FFFF, 17'h1FFFF, 3'd7, '1, '1, 16'hFFFF);
         end else if (p == 1) begin
            program_filter('0, '0, '0, '0, '0, '0);
         end else begin
            thr = {$urandom, $urandom};
            inc = {$urandom, $urandom};
            if ($urandom_range(0, 1)) inc &= {4{16'h0FFF}};
            program_filter(gain_pick(), gain_pick(), 3'($urandom_range(0, 7)),
                           thr, inc, 16'($urandom));
         end
         run_random_burst(105);
         await_filter_idle();
      end

      stall_enable = 1'b1;
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_filtered.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
